// ===== src/taes_pkg.sv =====
// Package for the triangular adjacency edge store: request and result types,
// opcode and status codes, field widths and the packed slot index function.
// Depends on nothing; used by the top level.
package taes_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int WEIGHT_BITS_DEF  = 32;

  localparam int OPC_W       = 3;
  localparam int VERT_W      = 5;
  localparam int VC_W        = 6;
  localparam int EXT_W       = 32;
  localparam int STAT_W      = 3;
  localparam int TOT_W       = 9;
  localparam int LIST_W      = 5;
  localparam int MAX_LIST    = 31;
  localparam int SLOT_FULL_W = 2 * VC_W;

  localparam logic [OPC_W-1:0] OP_ADD_VERTEX    = 3'd0;
  localparam logic [OPC_W-1:0] OP_INSERT_EDGE   = 3'd1;
  localparam logic [OPC_W-1:0] OP_REMOVE_EDGE   = 3'd2;
  localparam logic [OPC_W-1:0] OP_QUERY_EDGE    = 3'd3;
  localparam logic [OPC_W-1:0] OP_REMOVE_VERTEX = 3'd4;
  localparam logic [OPC_W-1:0] OP_LIST_INCIDENT = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK           = 3'd0;
  localparam logic [STAT_W-1:0] ST_SELF_LOOP    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EDGE_EXISTS  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_EDGE      = 3'd3;
  localparam logic [STAT_W-1:0] ST_OUT_OF_RANGE = 3'd4;

  typedef logic [TOT_W-1:0] tot_t;

  typedef struct packed {
    logic [OPC_W-1:0]         opcode;
    logic [VERT_W-1:0]        vertex_a;
    logic [VERT_W-1:0]        vertex_b;
    logic signed [EXT_W-1:0]  edge_weight_in;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic                     edge_present;
    logic signed [EXT_W-1:0]  edge_weight_out;
    logic [VERT_W-1:0]        other_vertex;
    logic [TOT_W-1:0]         total_edges;
    logic                     last;
  } rsp_t;

  // Packed lower-triangle slot of the pair (hi, lo) with lo < hi.
  function automatic logic [SLOT_FULL_W-1:0] slot_index(input logic [VC_W-1:0] hi,
                                                        input logic [VC_W-1:0] lo);
    logic [SLOT_FULL_W-1:0] prod;
    prod = SLOT_FULL_W'(hi) * (SLOT_FULL_W'(hi) - SLOT_FULL_W'(1));
    return (prod >> 1) + SLOT_FULL_W'(lo);
  endfunction

endpackage

// ===== src/taes_ram.sv =====
// Generic simple dual-port RAM: one write port and one registered read port.
// Width and depth are parameters; no other dependencies.
module taes_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 496,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/triangular_adjacency_edge_store_unit.sv =====
// Top level of the triangular adjacency edge store: request decode, sequencer,
// edge table read-modify-write and result register.
// Depends on taes_pkg and taes_ram.
//
// Edge weights and valid bits share one RAM word per vertex pair, read through
// the registered read port. A request is taken only while the sequencer is idle.
// Adding vertex n clears the n slots of its row one per cycle through the write
// port; this sweep is also what makes every slot valid-clean before use, so the
// table needs no clearing pass after reset. Removing or listing a vertex walks
// all present vertices one slot per cycle, slower while the result side stalls
// a listing.
module triangular_adjacency_edge_store_unit #(
  parameter int MAX_VERTICES = taes_pkg::MAX_VERTICES_DEF,
  parameter int WEIGHT_BITS  = taes_pkg::WEIGHT_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  taes_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output taes_pkg::rsp_t  rsp
);

  localparam int T_SIZE = MAX_VERTICES * (MAX_VERTICES - 1) / 2;
  localparam int ADDR_W = (T_SIZE > 1) ? $clog2(T_SIZE) : 1;
  localparam int VLIMIT = (MAX_VERTICES > 63) ? 63 : MAX_VERTICES;
  localparam int EC_W   = $clog2(T_SIZE + 1);
  localparam int RAM_W  = WEIGHT_BITS + 1;
  localparam int VC_W   = taes_pkg::VC_W;
  localparam int LIST_W = taes_pkg::LIST_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_CLEAR = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_SEND  = 3'd4;

  function automatic logic signed [taes_pkg::EXT_W-1:0] to_ext(
      input logic signed [WEIGHT_BITS-1:0] w);
    logic signed [63:0] wide;
    wide = 64'(w);
    return wide[taes_pkg::EXT_W-1:0];
  endfunction

  function automatic taes_pkg::rsp_t make_rsp(input logic [taes_pkg::STAT_W-1:0] st,
                                              input logic present,
                                              input logic signed [taes_pkg::EXT_W-1:0] w,
                                              input logic [taes_pkg::VERT_W-1:0] other);
    taes_pkg::rsp_t r;
    r.status          = st;
    r.edge_present    = present;
    r.edge_weight_out = w;
    r.other_vertex    = other;
    r.total_edges     = '0;
    r.last            = 1'b0;
    return r;
  endfunction

  logic [2:0]                state;
  logic [2:0]                op;
  logic [VC_W-1:0]           va;
  logic [ADDR_W-1:0]         cur_slot;
  logic [WEIGHT_BITS-1:0]    w_fit;
  logic [VC_W-1:0]           vertex_count;
  logic [EC_W-1:0]           edge_count;
  logic [VC_W-1:0]           cnt;
  logic                      chk_pend;
  logic [VC_W-1:0]           chk_i;
  logic [ADDR_W-1:0]         chk_slot;
  logic [LIST_W-1:0]         n_list;
  taes_pkg::rsp_t            hold;
  logic                      hold_valid;

  logic                      ram_wr_en;
  logic [ADDR_W-1:0]         ram_wr_addr;
  logic [RAM_W-1:0]          ram_wr_data;
  logic                      ram_rd_en;
  logic [ADDR_W-1:0]         ram_rd_addr;
  logic [RAM_W-1:0]          ram_rd_data;

  logic                      accept;
  logic [VC_W-1:0]           a_ext;
  logic [VC_W-1:0]           b_ext;
  logic                      a_bad;
  logic                      b_bad;
  logic                      pair_op;
  logic                      pair_go;
  logic [VC_W-1:0]           pair_hi;
  logic [VC_W-1:0]           pair_lo;
  logic [taes_pkg::SLOT_FULL_W-1:0] pair_full;
  logic [taes_pkg::SLOT_FULL_W-1:0] walk_full;
  logic [taes_pkg::SLOT_FULL_W-1:0] row_full;
  logic [VC_W-1:0]           walk_hi;
  logic [VC_W-1:0]           walk_lo;
  logic signed [63:0]        in_wide;

  logic                      rd_hit_valid;
  logic signed [WEIGHT_BITS-1:0] rd_weight;
  logic                      is_list;
  logic                      hit;
  logic                      take;
  logic                      out_free;
  logic                      advance;
  logic                      walk_more;
  logic                      clear_more;
  logic                      rsp_load;
  taes_pkg::rsp_t            rsp_next;

  assign accept    = req_valid && !req_stall;
  assign req_stall = (state != S_IDLE);

  assign a_ext   = {1'b0, req.vertex_a};
  assign b_ext   = {1'b0, req.vertex_b};
  assign a_bad   = (a_ext >= vertex_count);
  assign b_bad   = (b_ext >= vertex_count);
  assign pair_op = (req.opcode == taes_pkg::OP_INSERT_EDGE) ||
                   (req.opcode == taes_pkg::OP_REMOVE_EDGE) ||
                   (req.opcode == taes_pkg::OP_QUERY_EDGE);
  assign pair_go = accept && pair_op && !a_bad && !b_bad &&
                   (req.vertex_a != req.vertex_b);
  assign pair_hi = (a_ext > b_ext) ? a_ext : b_ext;
  assign pair_lo = (a_ext > b_ext) ? b_ext : a_ext;
  assign pair_full = taes_pkg::slot_index(pair_hi, pair_lo);
  assign row_full  = taes_pkg::slot_index(vertex_count, '0);
  assign walk_hi   = (va > cnt) ? va : cnt;
  assign walk_lo   = (va > cnt) ? cnt : va;
  assign walk_full = taes_pkg::slot_index(walk_hi, walk_lo);
  assign in_wide   = 64'(req.edge_weight_in);

  assign rd_hit_valid = ram_rd_data[WEIGHT_BITS];
  assign rd_weight    = ram_rd_data[WEIGHT_BITS-1:0];

  assign is_list    = (op == taes_pkg::OP_LIST_INCIDENT);
  assign hit        = chk_pend && rd_hit_valid && (chk_i != va);
  assign take       = hit && is_list && (n_list != LIST_W'(taes_pkg::MAX_LIST));
  assign out_free   = !rsp_valid || !rsp_stall;
  assign advance    = !(take && hold_valid && !out_free);
  assign walk_more  = (cnt < vertex_count);
  assign clear_more = (cnt != vertex_count);

  always_comb begin
    ram_rd_en   = 1'b0;
    ram_rd_addr = pair_full[ADDR_W-1:0];
    ram_wr_en   = 1'b0;
    ram_wr_addr = cur_slot;
    ram_wr_data = {1'b0, w_fit};
    case (state)
      S_IDLE: begin
        ram_rd_en = pair_go;
      end
      S_LOOK: begin
        if (op == taes_pkg::OP_INSERT_EDGE) begin
          ram_wr_en   = !rd_hit_valid;
          ram_wr_data = {1'b1, w_fit};
        end else if (op == taes_pkg::OP_REMOVE_EDGE) begin
          ram_wr_en = rd_hit_valid;
        end
      end
      S_CLEAR: begin
        ram_wr_en = clear_more;
      end
      S_WALK: begin
        ram_rd_en   = advance && walk_more;
        ram_rd_addr = walk_full[ADDR_W-1:0];
        ram_wr_en   = advance && hit && !is_list;
        ram_wr_addr = chk_slot;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    rsp_load = 1'b0;
    rsp_next = hold;
    case (state)
      S_WALK: begin
        rsp_load      = advance && take && hold_valid;
        rsp_next.last = 1'b0;
      end
      S_SEND: begin
        rsp_load      = out_free;
        rsp_next.last = 1'b1;
      end
      default: begin
      end
    endcase
    rsp_next.total_edges = taes_pkg::tot_t'(edge_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      edge_count   <= '0;
      chk_pend     <= 1'b0;
      hold_valid   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op       <= req.opcode;
            va       <= a_ext;
            cnt      <= '0;
            cur_slot <= pair_full[ADDR_W-1:0];
            w_fit    <= in_wide[WEIGHT_BITS-1:0];
            case (req.opcode)
              taes_pkg::OP_ADD_VERTEX: begin
                if (vertex_count >= VC_W'(VLIMIT)) begin
                  hold  <= make_rsp(taes_pkg::ST_OUT_OF_RANGE, 1'b0, '0, '0);
                  state <= S_SEND;
                end else begin
                  hold     <= make_rsp(taes_pkg::ST_OK, 1'b0, '0,
                                       vertex_count[taes_pkg::VERT_W-1:0]);
                  cur_slot <= row_full[ADDR_W-1:0];
                  state    <= S_CLEAR;
                end
              end
              taes_pkg::OP_INSERT_EDGE, taes_pkg::OP_REMOVE_EDGE,
              taes_pkg::OP_QUERY_EDGE: begin
                if (a_bad || b_bad) begin
                  hold  <= make_rsp(taes_pkg::ST_OUT_OF_RANGE, 1'b0, '0, '0);
                  state <= S_SEND;
                end else if (req.vertex_a == req.vertex_b) begin
                  hold  <= make_rsp(taes_pkg::ST_SELF_LOOP, 1'b0, '0, '0);
                  state <= S_SEND;
                end else begin
                  state <= S_LOOK;
                end
              end
              taes_pkg::OP_REMOVE_VERTEX, taes_pkg::OP_LIST_INCIDENT: begin
                if (a_bad) begin
                  hold  <= make_rsp(taes_pkg::ST_OUT_OF_RANGE, 1'b0, '0, '0);
                  state <= S_SEND;
                end else begin
                  chk_pend   <= 1'b0;
                  hold_valid <= 1'b0;
                  n_list     <= '0;
                  state      <= S_WALK;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        S_LOOK: begin
          state <= S_SEND;
          case (op)
            taes_pkg::OP_INSERT_EDGE: begin
              if (rd_hit_valid) begin
                hold <= make_rsp(taes_pkg::ST_EDGE_EXISTS, 1'b1, to_ext(rd_weight), '0);
              end else begin
                edge_count <= edge_count + 1'b1;
                hold       <= make_rsp(taes_pkg::ST_OK, 1'b1, to_ext(w_fit), '0);
              end
            end
            taes_pkg::OP_REMOVE_EDGE: begin
              if (rd_hit_valid) begin
                edge_count <= edge_count - 1'b1;
                hold       <= make_rsp(taes_pkg::ST_OK, 1'b0, '0, '0);
              end else begin
                hold <= make_rsp(taes_pkg::ST_NO_EDGE, 1'b0, '0, '0);
              end
            end
            default: begin
              if (rd_hit_valid) begin
                hold <= make_rsp(taes_pkg::ST_OK, 1'b1, to_ext(rd_weight), '0);
              end else begin
                hold <= make_rsp(taes_pkg::ST_NO_EDGE, 1'b0, '0, '0);
              end
            end
          endcase
        end

        S_CLEAR: begin
          if (clear_more) begin
            cur_slot <= cur_slot + 1'b1;
            cnt      <= cnt + 1'b1;
          end else begin
            vertex_count <= vertex_count + 1'b1;
            state        <= S_SEND;
          end
        end

        S_WALK: begin
          if (advance) begin
            if (hit && !is_list) begin
              edge_count <= edge_count - 1'b1;
            end
            if (take) begin
              hold       <= make_rsp(taes_pkg::ST_OK, 1'b1, to_ext(rd_weight),
                                     chk_i[taes_pkg::VERT_W-1:0]);
              hold_valid <= 1'b1;
              n_list     <= n_list + 1'b1;
            end
            if (walk_more) begin
              chk_pend <= 1'b1;
              chk_i    <= cnt;
              chk_slot <= walk_full[ADDR_W-1:0];
              cnt      <= cnt + 1'b1;
            end else begin
              chk_pend <= 1'b0;
              if (!chk_pend) begin
                if (!is_list || !hold_valid) begin
                  hold <= make_rsp(taes_pkg::ST_OK, 1'b0, '0, '0);
                end
                state <= S_SEND;
              end
            end
          end
        end

        S_SEND: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  taes_ram #(
    .WIDTH (RAM_W),
    .DEPTH (T_SIZE)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== dv/triangular_adjacency_edge_store_unit_tb.sv =====
// Self-checking testbench for triangular_adjacency_edge_store_unit: directed and random
// requests with random idling on both sides, checked against a behavioral edge table.
// Depends on taes_pkg and the top level of the block.
module triangular_adjacency_edge_store_unit_tb;
  import taes_pkg::*;

  localparam int MAXV   = MAX_VERTICES_DEF;
  localparam int WB     = WEIGHT_BITS_DEF;
  localparam int VLIMIT = (MAXV > 63) ? 63 : MAXV;
  localparam int PAIRS  = MAXV * (MAXV - 1) / 2;
  localparam logic [OPC_W-1:0] OP_RESERVED_LO = 3'd6;
  localparam logic [OPC_W-1:0] OP_RESERVED_HI = 3'd7;

  typedef struct {
    req_t op;
    bit   drain;
  } pending_op_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  pending_op_t op_queue[$];
  rsp_t due_results[$];

  logic [31:0] pair_wt[PAIRS];
  bit pair_on[PAIRS];
  int unsigned vcount = 0;
  int unsigned ecount = 0;

  int unsigned gen_vc = 0;
  int unsigned gen_items = 0;
  bit drain_next = 1'b0;

  bit req_taken = 1'b0;
  int unsigned reqs_taken = 0;
  int unsigned send_gap = 0;
  bit send_calm = 1'b0;
  int unsigned rsp_gap = 0;
  bit recv_calm = 1'b0;
  int unsigned hold_left = 0;
  int unsigned next_hold_at = 40;
  int unsigned err_count = 0;

  triangular_adjacency_edge_store_unit DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int unsigned pair_slot(int unsigned a, int unsigned b);
    int unsigned hi;
    int unsigned lo;
    int unsigned idx;
    hi = (a > b) ? a : b;
    lo = (a > b) ? b : a;
    idx = hi * (hi - 1) / 2 + lo;
    return (idx < PAIRS) ? idx : 0;
  endfunction

  function automatic logic [31:0] fit_weight(logic [31:0] w);
    logic signed [63:0] x;
    x = {{32{w[31]}}, w};
    x = x <<< (64 - WB);
    x = x >>> (64 - WB);
    return x[31:0];
  endfunction

  function automatic rsp_t result_of(logic [STAT_W-1:0] st, logic present, logic [31:0] w,
                                     int unsigned other, logic fin);
    rsp_t r;
    r.status = st;
    r.edge_present = present;
    r.edge_weight_out = w;
    r.other_vertex = VERT_W'(other);
    r.total_edges = TOT_W'(ecount);
    r.last = fin;
    return r;
  endfunction

  // Updates the edge table for one accepted request and queues the results it causes.
  function automatic void apply_graph_op(req_t r);
    int unsigned a;
    int unsigned b;
    int unsigned s;
    int unsigned n;
    rsp_t tail;
    a = r.vertex_a;
    b = r.vertex_b;
    case (r.opcode)
      OP_ADD_VERTEX: begin
        if (vcount >= VLIMIT) begin
          due_results.push_back(result_of(ST_OUT_OF_RANGE, 0, 0, 0, 1));
        end else begin
          for (int unsigned i = 0; i < vcount; i++) pair_on[pair_slot(vcount, i)] = 1'b0;
          due_results.push_back(result_of(ST_OK, 0, 0, vcount, 1));
          vcount++;
        end
      end
      OP_INSERT_EDGE, OP_REMOVE_EDGE, OP_QUERY_EDGE: begin
        if (a >= vcount || b >= vcount) begin
          due_results.push_back(result_of(ST_OUT_OF_RANGE, 0, 0, 0, 1));
        end else if (a == b) begin
          due_results.push_back(result_of(ST_SELF_LOOP, 0, 0, 0, 1));
        end else begin
          s = pair_slot(a, b);
          if (r.opcode == OP_INSERT_EDGE) begin
            if (pair_on[s]) begin
              due_results.push_back(result_of(ST_EDGE_EXISTS, 1, pair_wt[s], 0, 1));
            end else begin
              pair_wt[s] = fit_weight(r.edge_weight_in);
              pair_on[s] = 1'b1;
              ecount++;
              due_results.push_back(result_of(ST_OK, 1, pair_wt[s], 0, 1));
            end
          end else if (!pair_on[s]) begin
            due_results.push_back(result_of(ST_NO_EDGE, 0, 0, 0, 1));
          end else if (r.opcode == OP_REMOVE_EDGE) begin
            pair_on[s] = 1'b0;
            ecount--;
            due_results.push_back(result_of(ST_OK, 0, 0, 0, 1));
          end else begin
            due_results.push_back(result_of(ST_OK, 1, pair_wt[s], 0, 1));
          end
        end
      end
      OP_REMOVE_VERTEX, OP_LIST_INCIDENT: begin
        if (a >= vcount) begin
          due_results.push_back(result_of(ST_OUT_OF_RANGE, 0, 0, 0, 1));
        end else begin
          n = 0;
          for (int unsigned i = 0; i < vcount; i++) begin
            if (i != a) begin
              s = pair_slot(a, i);
              if (pair_on[s]) begin
                if (r.opcode == OP_REMOVE_VERTEX) begin
                  pair_on[s] = 1'b0;
                  ecount--;
                end else if (n < MAX_LIST) begin
                  due_results.push_back(result_of(ST_OK, 1, pair_wt[s], i, 0));
                  n++;
                end
              end
            end
          end
          if (r.opcode == OP_REMOVE_VERTEX || n == 0) begin
            due_results.push_back(result_of(ST_OK, 0, 0, 0, 1));
          end else begin
            tail = due_results.pop_back();
            tail.last = 1'b1;
            due_results.push_back(tail);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic string rsp_text(rsp_t r);
    return $sformatf("status=%0d present=%0d weight=%0d other=%0d total=%0d last=%0d",
                     r.status, r.edge_present, r.edge_weight_out, r.other_vertex,
                     r.total_edges, r.last);
  endfunction

  task automatic flag_fault(string msg);
    err_count++;
    if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic push_op(logic [OPC_W-1:0] op, int unsigned a, int unsigned b,
                         logic [31:0] w);
    pending_op_t p;
    p.op.opcode = op;
    p.op.vertex_a = VERT_W'(a);
    p.op.vertex_b = VERT_W'(b);
    p.op.edge_weight_in = w;
    p.drain = drain_next;
    drain_next = 1'b0;
    op_queue.push_back(p);
    if (op == OP_ADD_VERTEX && gen_vc < VLIMIT) gen_vc++;
    if (op <= OP_LIST_INCIDENT) gen_items++;
  endtask

  function automatic int unsigned pick_vertex();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (gen_vc == 0 || k == 0) return $urandom_range(0, 31);
    if (k < 4) return $urandom_range(0, ((gen_vc < 6) ? gen_vc : 6) - 1);
    return $urandom_range(0, gen_vc - 1);
  endfunction

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Connects one vertex to many others, lists it, and sometimes removes and lists it again.
  task automatic build_star(bit full);
    int unsigned hub;
    hub = $urandom_range(0, gen_vc - 1);
    for (int unsigned v = 0; v < gen_vc; v++) begin
      if (v != hub && (full || $urandom_range(0, 2) == 0)) begin
        if ($urandom_range(0, 1)) push_op(OP_INSERT_EDGE, hub, v, pick_weight());
        else push_op(OP_INSERT_EDGE, v, hub, pick_weight());
      end
    end
    push_op(OP_LIST_INCIDENT, hub, pick_vertex(), pick_weight());
    if ($urandom_range(0, 2) == 0) begin
      push_op(OP_REMOVE_VERTEX, hub, pick_vertex(), pick_weight());
      push_op(OP_LIST_INCIDENT, hub, pick_vertex(), pick_weight());
    end
  endtask

  task automatic push_random_op();
    int unsigned a;
    int unsigned b;
    logic [OPC_W-1:0] op;
    case ($urandom_range(0, 11))
      0: op = OP_ADD_VERTEX;
      1, 2, 3, 4: op = OP_INSERT_EDGE;
      5: op = OP_REMOVE_EDGE;
      6, 7: op = OP_QUERY_EDGE;
      8: op = OP_REMOVE_VERTEX;
      default: op = OP_LIST_INCIDENT;
    endcase
    if (gen_vc < VLIMIT && $urandom_range(0, 19) < 6) op = OP_ADD_VERTEX;
    if ($urandom_range(0, 19) == 0) op = $urandom_range(0, 1) ? OP_RESERVED_HI : OP_RESERVED_LO;
    a = pick_vertex();
    b = ($urandom_range(0, 11) == 0) ? a : pick_vertex();
    push_op(op, a, b, pick_weight());
  endtask

  always @(negedge clk) begin : drive_req
    bit offer;
    offer = req_valid;
    if (rst) begin
      offer = 1'b0;
    end else begin
      if (req_valid && req_taken) begin
        offer = 1'b0;
        req_taken = 1'b0;
        void'(op_queue.pop_front());
        send_gap = send_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (op_queue.size() > 0) begin
          if (!op_queue[0].drain || due_results.size() == 0) begin
            offer = 1'b1;
            req <= op_queue[0].op;
          end
        end
      end
    end
    req_valid <= offer;
  end

  always @(posedge clk) begin : take_req
    if (!rst && req_valid && !req_stall) begin
      apply_graph_op(req);
      req_taken = 1'b1;
      reqs_taken++;
    end
  end

  always @(negedge clk) begin : drive_stall
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else if (reqs_taken >= next_hold_at) begin
      hold_left = 250;
      next_hold_at += 110;
      rsp_stall <= 1'b1;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    string bad;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_gap = recv_calm ? 0 : $urandom_range(0, 17);
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      if (due_results.size() == 0) begin
        flag_fault($sformatf("result with none outstanding: %s", rsp_text(rsp)));
      end else begin
        want = due_results.pop_front();
        bad = "";
        if (rsp.status != want.status) bad = {bad, " status"};
        if (rsp.edge_present != want.edge_present) bad = {bad, " edge_present"};
        if (rsp.edge_weight_out != want.edge_weight_out) bad = {bad, " edge_weight_out"};
        if (rsp.other_vertex != want.other_vertex) bad = {bad, " other_vertex"};
        if (rsp.total_edges != want.total_edges) bad = {bad, " total_edges"};
        if (rsp.last != want.last) bad = {bad, " last"};
        if (bad != "") begin
          flag_fault($sformatf("mismatch in%s: expected %s, got %s", bad,
                               rsp_text(want), rsp_text(rsp)));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned item_goal;
    bit full_star_done;
    full_star_done = 1'b0;

    push_op(OP_QUERY_EDGE, 0, 0, 0);
    push_op(OP_LIST_INCIDENT, 0, 0, 0);
    push_op(OP_REMOVE_VERTEX, 31, 0, 0);
    push_op(OP_ADD_VERTEX, 0, 0, 0);
    push_op(OP_ADD_VERTEX, 0, 0, 0);
    push_op(OP_ADD_VERTEX, 0, 0, 0);
    push_op(OP_INSERT_EDGE, 0, 1, 32'h7FFF_FFFF);
    push_op(OP_INSERT_EDGE, 1, 0, 32'h0000_0000);
    push_op(OP_INSERT_EDGE, 2, 2, 32'h1234_5678);
    push_op(OP_INSERT_EDGE, 0, 2, 32'h8000_0000);
    push_op(OP_QUERY_EDGE, 2, 0, 0);
    push_op(OP_QUERY_EDGE, 1, 2, 0);
    push_op(OP_REMOVE_EDGE, 1, 2, 0);
    push_op(OP_LIST_INCIDENT, 0, 0, 0);
    push_op(OP_LIST_INCIDENT, 1, 0, 0);
    push_op(OP_REMOVE_EDGE, 1, 0, 0);
    push_op(OP_INSERT_EDGE, 2, 1, 32'hFFFF_FFFF);
    push_op(OP_REMOVE_VERTEX, 2, 0, 0);
    push_op(OP_LIST_INCIDENT, 2, 0, 0);
    push_op(OP_QUERY_EDGE, 0, 31, 0);
    push_op(OP_INSERT_EDGE, 31, 0, 32'hFFFF_FFFF);
    push_op(OP_RESERVED_LO, 31, 31, 32'hFFFF_FFFF);
    push_op(OP_RESERVED_HI, 0, 0, 0);
    push_op(OP_ADD_VERTEX, 0, 0, 0);
    drain_next = 1'b1;
    push_op(OP_INSERT_EDGE, 3, 0, 0);

    drain_next = 1'b1;
    item_goal = 230;
    while (gen_items < item_goal || !full_star_done) begin
      if ($urandom_range(0, 39) == 0) drain_next = 1'b1;
      if (gen_vc == VLIMIT && !full_star_done) begin
        build_star(1'b1);
        push_op(OP_ADD_VERTEX, 0, 0, 0);
        full_star_done = 1'b1;
      end else if (gen_vc >= 3 && $urandom_range(0, 11) == 0) begin
        build_star(1'b0);
      end else begin
        push_random_op();
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (op_queue.size() > 0 || due_results.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
